// ===== rtl/fac_pkg.sv =====
// fac_pkg: shared types, codes and constants of the fit allocator
// no dependencies; imported by the top level and fac_ctrl
`timescale 1ns / 1ps

package fac_pkg;

    localparam int LEN_W          = 24;
    localparam int ONE_KB         = 1024;
    localparam int ONE_MB         = ONE_KB * ONE_KB;
    localparam int INIT_BASE      = 3 * ONE_MB;
    localparam int MERGE_CAP_RST  = 4 * ONE_MB;

    localparam int FREE_ENTRIES_DEF = 32;
    localparam int USED_ENTRIES_DEF = 32;
    localparam int ADDR_BITS_DEF    = 24;
    localparam int INIT_BLOCKS_DEF  = 5;

    // request codes
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_TERM  = 2'd2;

    // result codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_FIT    = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    // configuration register indexes
    localparam logic CFG_FIT_MODE  = 1'b0;
    localparam logic CFG_MERGE_CAP = 1'b1;

    typedef struct packed {
        logic [1:0]       func;
        logic [15:0]      proc_id;
        logic [15:0]      block_tag;
        logic [LEN_W-1:0] req_size;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [LEN_W-1:0] grant_addr;
        logic [5:0]       freed_count;
    } t_out;

    typedef struct packed {
        logic             fit_mode;
        logic [LEN_W-1:0] merge_cap;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_PICK,
        ST_A_SH_RD,
        ST_A_SH_WR,
        ST_A_USED,
        ST_U_UP_RD,
        ST_U_UP_WR,
        ST_U_RD,
        ST_U_CHK,
        ST_M_RD,
        ST_M_STEP,
        ST_U_DN_RD,
        ST_U_DN_WR,
        ST_DONE
    } t_state;

    // sizes of the blocks laid out at reset
    function automatic logic [LEN_W-1:0] f_init_len(input logic [2:0] idx);
        logic [LEN_W-1:0] len;
        case (idx)
            3'd1, 3'd2: len = LEN_W'(2 * ONE_MB);
            3'd3, 3'd4: len = LEN_W'(4 * ONE_MB);
            default:    len = LEN_W'(ONE_MB);
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/fit_allocator_with_coalescing.sv =====
// fit_allocator_with_coalescing: top level; configuration registers, result register
// depends on fac_pkg, fac_ram and fac_ctrl
//
//   port group   dir  handshake              payload
//   i_in_*       in   i_in_valid/o_in_stall  fac_pkg::t_in
//   o_out_*      out  o_out_valid/i_out_stall fac_pkg::t_out
//   i_cfg_*      in   i_cfg_we               i_cfg_addr, i_cfg_wdata
//
// one request at a time; each table access is a read state followed by a step state
// allocate: a scan of the free entries, then a shift of the free entries that follow
// an exact fit, and in first fit a move of every used entry up to open the head slot
// free/terminate: a scan of the used entries, then for each release a count pass and a
// write merge pass over the free entries, then a shift of the used entries that follow
// after reset the INIT_BLOCKS initial free blocks are laid out, with input stalled
// a finished result waits in the output register while the next request runs
`timescale 1ns / 1ps

module fit_allocator_with_coalescing #(
    parameter int FREE_ENTRIES = fac_pkg::FREE_ENTRIES_DEF,
    parameter int USED_ENTRIES = fac_pkg::USED_ENTRIES_DEF,
    parameter int ADDR_BITS    = fac_pkg::ADDR_BITS_DEF,
    parameter int INIT_BLOCKS  = fac_pkg::INIT_BLOCKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  fac_pkg::t_in             i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output fac_pkg::t_out            o_out,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_addr,
    input  logic [fac_pkg::LEN_W-1:0] i_cfg_wdata
);

    import fac_pkg::*;

    localparam int FR_W = ADDR_BITS + LEN_W;
    localparam int US_W = ADDR_BITS + LEN_W + 32;
    localparam int FI   = $clog2(FREE_ENTRIES);
    localparam int UI   = $clog2(USED_ENTRIES);

    t_cfg  r_cfg;
    t_out  r_out;
    logic  r_out_valid;
    t_out  w_res;
    logic  w_res_valid, w_res_take;

    logic            w_fr_we, w_us_we;
    logic [FI-1:0]   w_fr_waddr, w_fr_raddr;
    logic [UI-1:0]   w_us_waddr, w_us_raddr;
    logic [FR_W-1:0] w_fr_wdata, w_fr_rdata;
    logic [US_W-1:0] w_us_wdata, w_us_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fit_mode  <= 1'b1;
            r_cfg.merge_cap <= LEN_W'(MERGE_CAP_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FIT_MODE:  r_cfg.fit_mode  <= i_cfg_wdata[0];
                CFG_MERGE_CAP: r_cfg.merge_cap <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // result register frees the sequencer once the result is loaded
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) r_out <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    fac_ram #(.DEPTH(FREE_ENTRIES), .WIDTH(FR_W)) u_free_tbl (
        .i_clk   (i_clk),
        .i_we    (w_fr_we),
        .i_waddr (w_fr_waddr),
        .i_wdata (w_fr_wdata),
        .i_raddr (w_fr_raddr),
        .o_rdata (w_fr_rdata)
    );

    fac_ram #(.DEPTH(USED_ENTRIES), .WIDTH(US_W)) u_used_tbl (
        .i_clk   (i_clk),
        .i_we    (w_us_we),
        .i_waddr (w_us_waddr),
        .i_wdata (w_us_wdata),
        .i_raddr (w_us_raddr),
        .o_rdata (w_us_rdata)
    );

    fac_ctrl #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .USED_ENTRIES (USED_ENTRIES),
        .ADDR_BITS    (ADDR_BITS),
        .INIT_BLOCKS  (INIT_BLOCKS),
        .FR_W         (FR_W),
        .US_W         (US_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take),
        .o_fr_we     (w_fr_we),
        .o_fr_waddr  (w_fr_waddr),
        .o_fr_wdata  (w_fr_wdata),
        .o_fr_raddr  (w_fr_raddr),
        .i_fr_rdata  (w_fr_rdata),
        .o_us_we     (w_us_we),
        .o_us_waddr  (w_us_waddr),
        .o_us_wdata  (w_us_wdata),
        .o_us_raddr  (w_us_raddr),
        .i_us_rdata  (w_us_rdata)
    );

endmodule

// ===== rtl/fac_ram.sv =====
// fac_ram: single write port, single read port table with registered read
// used for the free table and the used table; no package needed
`timescale 1ns / 1ps

module fac_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fac_ctrl.sv =====
// fac_ctrl: request sequencer; scans, shifts, inserts and merges table entries
// depends on fac_pkg; drives the two fac_ram tables held by the top level
`timescale 1ns / 1ps

module fac_ctrl #(
    parameter int FREE_ENTRIES = 32,
    parameter int USED_ENTRIES = 32,
    parameter int ADDR_BITS    = 24,
    parameter int INIT_BLOCKS  = 5,
    parameter int FR_W         = ADDR_BITS + 24,
    parameter int US_W         = ADDR_BITS + 56
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fac_pkg::t_cfg                   i_cfg,
    input  logic                            i_in_valid,
    input  fac_pkg::t_in                    i_in,
    output logic                            o_in_stall,
    output logic                            o_res_valid,
    output fac_pkg::t_out                   o_res,
    input  logic                            i_res_take,
    output logic                            o_fr_we,
    output logic [$clog2(FREE_ENTRIES)-1:0] o_fr_waddr,
    output logic [FR_W-1:0]                 o_fr_wdata,
    output logic [$clog2(FREE_ENTRIES)-1:0] o_fr_raddr,
    input  logic [FR_W-1:0]                 i_fr_rdata,
    output logic                            o_us_we,
    output logic [$clog2(USED_ENTRIES)-1:0] o_us_waddr,
    output logic [US_W-1:0]                 o_us_wdata,
    output logic [$clog2(USED_ENTRIES)-1:0] o_us_raddr,
    input  logic [US_W-1:0]                 i_us_rdata
);

    import fac_pkg::*;

    localparam int FI = $clog2(FREE_ENTRIES);
    localparam int FC = $clog2(FREE_ENTRIES + 1);
    localparam int OC = $clog2(FREE_ENTRIES + 2);
    localparam int UI = $clog2(USED_ENTRIES);
    localparam int UC = $clog2(USED_ENTRIES + 1);
    localparam int AW = ADDR_BITS;
    localparam int EW = ((AW > LEN_W) ? AW : LEN_W) + 1;

    t_state r_state, n_state;
    t_in    r_in;

    logic [FC-1:0]    r_free_n, r_f, r_pick;
    logic [OC-1:0]    r_o;
    logic [UC-1:0]    r_used_n, r_k, r_j;
    logic             r_found, r_refused, r_ins, r_accv, r_pass;
    logic [AW-1:0]    r_pick_start, r_rel_start, r_acc_start, r_grant;
    logic [LEN_W-1:0] r_pick_len, r_rel_len, r_acc_len;
    logic [1:0]       r_status;
    logic [5:0]       r_freed;

    logic             w_in_acc;
    logic [AW-1:0]    w_fr_start, w_us_start;
    logic [LEN_W-1:0] w_fr_len, w_us_len;
    logic [15:0]      w_us_owner, w_us_label;
    logic             w_fits, w_exact, w_full, w_match;
    logic             w_fend, w_take_new, w_adj, w_merge, w_emit, w_mdone;
    logic [AW-1:0]    w_el_start;
    logic [LEN_W-1:0] w_el_len;
    logic [LEN_W:0]   w_sum;
    logic [FC-1:0]    w_f_inc;
    logic [UC-1:0]    w_j_inc;
    logic             w_fr_last, w_us_last;
    logic [US_W-1:0]  w_new_used;

    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_fr_start = i_fr_rdata[FR_W-1:LEN_W];
    assign w_fr_len   = i_fr_rdata[LEN_W-1:0];
    assign w_us_start = i_us_rdata[US_W-1 -: AW];
    assign w_us_len   = i_us_rdata[32 +: LEN_W];
    assign w_us_owner = i_us_rdata[31:16];
    assign w_us_label = i_us_rdata[15:0];
    assign w_fits     = w_fr_len >= r_in.req_size;
    assign w_exact    = r_pick_len == r_in.req_size;
    assign w_full     = r_used_n == UC'(USED_ENTRIES);
    assign w_match    = (w_us_owner == r_in.proc_id)
                        && ((r_in.func == FUNC_TERM) || (w_us_label == r_in.block_tag));
    assign w_f_inc    = r_f + 1'b1;
    assign w_j_inc    = r_j + 1'b1;
    assign w_fr_last  = w_f_inc >= r_free_n;
    assign w_us_last  = w_j_inc >= r_used_n;
    assign w_new_used = {r_grant, r_in.req_size, r_in.proc_id, r_in.block_tag};

    // merge stream: free entries in order with the released block slotted in
    assign w_fend     = r_f == r_free_n;
    assign w_take_new = !r_ins && (w_fend || (w_fr_start > r_rel_start));
    assign w_el_start = w_take_new ? r_rel_start : w_fr_start;
    assign w_el_len   = w_take_new ? r_rel_len : w_fr_len;
    assign w_adj      = (EW'(r_acc_start) + EW'(r_acc_len)) == EW'(w_el_start);
    assign w_sum      = {1'b0, r_acc_len} + {1'b0, w_el_len};
    assign w_merge    = r_accv && w_adj && (w_sum <= {1'b0, i_cfg.merge_cap});
    assign w_emit     = r_accv && !w_merge;
    assign w_mdone    = r_ins && w_fend;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:    if (r_f == FC'(INIT_BLOCKS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.func)
                        FUNC_ALLOC: begin
                            if (w_full || (i_in.req_size == '0)) n_state = ST_DONE;
                            else n_state = ST_A_RD;
                        end
                        FUNC_FREE, FUNC_TERM: n_state = ST_U_RD;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_A_RD:    n_state = w_fend ? ST_A_PICK : ST_A_CHK;
            ST_A_CHK:   n_state = (w_fits && !i_cfg.fit_mode) ? ST_A_PICK : ST_A_RD;
            ST_A_PICK: begin
                if (!r_found) n_state = ST_DONE;
                else if (w_exact) n_state = ST_A_SH_RD;
                else n_state = ST_A_USED;
            end
            ST_A_SH_RD: n_state = w_fr_last ? ST_A_USED : ST_A_SH_WR;
            ST_A_SH_WR: n_state = ST_A_SH_RD;
            ST_A_USED:  n_state = i_cfg.fit_mode ? ST_DONE : ST_U_UP_RD;
            ST_U_UP_RD: n_state = (r_j == '0) ? ST_DONE : ST_U_UP_WR;
            ST_U_UP_WR: n_state = ST_U_UP_RD;
            ST_U_RD:    n_state = (r_k == r_used_n) ? ST_DONE : ST_U_CHK;
            ST_U_CHK:   n_state = w_match ? ST_M_RD : ST_U_RD;
            ST_M_RD:    n_state = ST_M_STEP;
            ST_M_STEP: begin
                if (!w_mdone) n_state = ST_M_RD;
                else if (r_pass) n_state = ST_U_DN_RD;
                else if (r_o < OC'(FREE_ENTRIES)) n_state = ST_M_RD;
                else if (r_in.func == FUNC_FREE) n_state = ST_DONE;
                else n_state = ST_U_RD;
            end
            ST_U_DN_RD: begin
                if (!w_us_last) n_state = ST_U_DN_WR;
                else if (r_in.func == FUNC_FREE) n_state = ST_DONE;
                else n_state = ST_U_RD;
            end
            ST_U_DN_WR: n_state = ST_U_DN_RD;
            ST_DONE:    if (i_res_take) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // table accesses
    always_comb begin
        o_fr_we    = 1'b0;
        o_fr_waddr = r_f[FI-1:0];
        o_fr_wdata = i_fr_rdata;
        o_fr_raddr = r_f[FI-1:0];
        o_us_we    = 1'b0;
        o_us_waddr = r_j[UI-1:0];
        o_us_wdata = i_us_rdata;
        o_us_raddr = r_k[UI-1:0];
        case (r_state)
            ST_INIT: begin
                o_fr_we    = 1'b1;
                o_fr_wdata = {r_rel_start, f_init_len(r_f[2:0])};
            end
            ST_A_PICK: begin
                o_fr_we    = r_found && !w_exact;
                o_fr_waddr = r_pick[FI-1:0];
                o_fr_wdata = {r_pick_start + AW'(r_in.req_size), r_pick_len - r_in.req_size};
            end
            ST_A_SH_RD: o_fr_raddr = w_f_inc[FI-1:0];
            ST_A_SH_WR: o_fr_we = 1'b1;
            ST_A_USED: begin
                o_us_we    = i_cfg.fit_mode;
                o_us_waddr = r_used_n[UI-1:0];
                o_us_wdata = w_new_used;
            end
            ST_U_UP_RD: begin
                o_us_we    = r_j == '0;
                o_us_waddr = '0;
                o_us_wdata = w_new_used;
                o_us_raddr = UI'(r_j - 1'b1);
            end
            ST_U_UP_WR: o_us_we = 1'b1;
            ST_M_STEP: begin
                o_fr_we    = r_pass && (w_mdone || w_emit);
                o_fr_waddr = r_o[FI-1:0];
                o_fr_wdata = {r_acc_start, r_acc_len};
            end
            ST_U_DN_RD: o_us_raddr = w_j_inc[UI-1:0];
            ST_U_DN_WR: o_us_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_free_n    <= '0;
            r_used_n    <= '0;
            r_f         <= '0;
            r_rel_start <= AW'(INIT_BASE);
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_INIT: begin
                    r_rel_start <= r_rel_start + AW'(f_init_len(r_f[2:0]));
                    r_f         <= w_f_inc;
                    if (r_f == FC'(INIT_BLOCKS - 1)) r_free_n <= FC'(INIT_BLOCKS);
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_in      <= i_in;
                        r_grant   <= '0;
                        r_freed   <= '0;
                        r_found   <= 1'b0;
                        r_refused <= 1'b0;
                        r_f       <= '0;
                        r_k       <= '0;
                        r_status  <= STAT_NOT_FOUND;
                        if (i_in.func == FUNC_ALLOC) begin
                            if (w_full) r_status <= STAT_FULL;
                            else if (i_in.req_size == '0) r_status <= STAT_NO_FIT;
                        end
                    end
                end
                ST_A_CHK: begin
                    if (w_fits && (!i_cfg.fit_mode || !r_found || (w_fr_len < r_pick_len)))
                    begin
                        r_found      <= 1'b1;
                        r_pick       <= r_f;
                        r_pick_start <= w_fr_start;
                        r_pick_len   <= w_fr_len;
                    end
                    r_f <= w_f_inc;
                end
                ST_A_PICK: begin
                    if (!r_found) begin
                        r_status <= STAT_NO_FIT;
                    end else begin
                        r_grant <= r_pick_start;
                        r_f     <= r_pick;
                    end
                end
                ST_A_SH_RD: if (w_fr_last) r_free_n <= r_free_n - 1'b1;
                ST_A_SH_WR: r_f <= w_f_inc;
                ST_A_USED: begin
                    if (i_cfg.fit_mode) begin
                        r_used_n <= r_used_n + 1'b1;
                        r_status <= STAT_OK;
                    end
                    r_j <= r_used_n;
                end
                ST_U_UP_RD: begin
                    if (r_j == '0) begin
                        r_used_n <= r_used_n + 1'b1;
                        r_status <= STAT_OK;
                    end
                end
                ST_U_UP_WR: r_j <= r_j - 1'b1;
                ST_U_RD: begin
                    if ((r_k == r_used_n) && (r_in.func == FUNC_TERM)) begin
                        if (r_refused) r_status <= STAT_FULL;
                        else if (r_found) r_status <= STAT_OK;
                    end
                end
                ST_U_CHK: begin
                    if (w_match) begin
                        r_found     <= 1'b1;
                        r_rel_start <= w_us_start;
                        r_rel_len   <= w_us_len;
                        r_f         <= '0;
                        r_o         <= '0;
                        r_ins       <= 1'b0;
                        r_accv      <= 1'b0;
                        r_pass      <= 1'b0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_M_STEP: begin
                    if (w_mdone) begin
                        if (r_pass) begin
                            r_free_n <= FC'(r_o + 1'b1);
                            r_j      <= r_k;
                        end else if (r_o < OC'(FREE_ENTRIES)) begin
                            r_pass <= 1'b1;
                            r_f    <= '0;
                            r_o    <= '0;
                            r_ins  <= 1'b0;
                            r_accv <= 1'b0;
                        end else begin
                            // table would overflow: block stays in use
                            r_refused <= 1'b1;
                            r_status  <= STAT_FULL;
                            r_k       <= r_k + 1'b1;
                        end
                    end else begin
                        if (w_take_new) r_ins <= 1'b1;
                        else r_f <= w_f_inc;
                        if (w_merge) begin
                            r_acc_len <= w_sum[LEN_W-1:0];
                        end else begin
                            r_acc_start <= w_el_start;
                            r_acc_len   <= w_el_len;
                            r_accv      <= 1'b1;
                            if (w_emit) r_o <= r_o + 1'b1;
                        end
                    end
                end
                ST_U_DN_RD: begin
                    if (w_us_last) begin
                        r_used_n <= r_used_n - 1'b1;
                        r_freed  <= r_freed + 1'b1;
                        if (r_in.func == FUNC_FREE) r_status <= STAT_OK;
                    end
                end
                ST_U_DN_WR: r_j <= w_j_inc;
                default: ;
            endcase
        end
    end

    assign o_in_stall             = r_state != ST_IDLE;
    assign o_res_valid            = r_state == ST_DONE;
    assign o_res.status           = r_status;
    assign o_res.grant_addr       = LEN_W'(r_grant);
    assign o_res.freed_count      = r_freed;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_n <= FC'(FREE_ENTRIES))
        else $error("free count beyond table depth");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_n <= UC'(USED_ENTRIES))
        else $error("used count beyond table depth");

    // merge writeback never overtakes entries still to be read
    a_merge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_M_STEP && o_fr_we && !w_mdone) |->
            ({1'b0, r_o} < ({1'b0, OC'(r_f)} + (OC + 1)'(r_ins))))
        else $error("merge write ahead of read");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != ST_IDLE))
        else $error("accepted request not started");

    a_alloc_grows_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used_n != $past(r_used_n) && $past(r_used_n) < r_used_n) |->
            (r_in.func == FUNC_ALLOC))
        else $error("used table grew outside allocate");

endmodule
